[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Any property, clocked on clk, off while rst_n is low.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    `ASSERT_PROP(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    `ASSERT_PROP(label, (ante) |=> (cons), msg)

`endif

[sv/psgfs_pkg.sv]
// ----------------------------------------------------------------------------
// psgfs_pkg
// Types and constants shared by the table fill/sum block.
// ----------------------------------------------------------------------------
package psgfs_pkg;

    localparam int INDEX_W     = 10;
    localparam int VALUE_W     = 32;
    localparam int SUM_W       = 42;
    localparam int SIZE_W      = 11;
    localparam int DEPTH_DEF   = 1024;
    localparam int STAMP_W_DEF = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    // Request actions; code 3 has no meaning and falls to default arms.
    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_SET  = 2'd1,
        ACT_FILL = 2'd2
    } action_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Command from the sequencer to the update datapath.
    typedef struct packed {
        logic       commit;
        logic [1:0] action;
    } pfs_cmd_t;

endpackage

[sv/psgfs_table.sv]
// ----------------------------------------------------------------------------
// psgfs_table
// Entry memory: value and write stamp per entry, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module psgfs_table
    import psgfs_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int STAMP_WIDTH = STAMP_W_DEF
)
(
    input  logic                   clk,
    input  logic                   rd_en,
    input  logic [INDEX_W-1:0]     rd_index,
    output logic [VALUE_W-1:0]     rd_value,
    output logic [STAMP_WIDTH-1:0] rd_stamp,
    input  logic                   wr_en,
    input  logic [INDEX_W-1:0]     wr_index,
    input  logic [VALUE_W-1:0]     wr_value,
    input  logic [STAMP_WIDTH-1:0] wr_stamp
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EXT_W  = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
    localparam int WORD_W = VALUE_W + STAMP_WIDTH;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_word_reg;
    logic [EXT_W-1:0]  rd_ext;
    logic [EXT_W-1:0]  wr_ext;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    assign rd_ext  = EXT_W'(rd_index);
    assign wr_ext  = EXT_W'(wr_index);
    assign rd_addr = rd_ext[ADDR_W-1:0];
    assign wr_addr = wr_ext[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_value, wr_stamp};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    assign rd_value = rd_word_reg[WORD_W-1:STAMP_WIDTH];
    assign rd_stamp = rd_word_reg[STAMP_WIDTH-1:0];

endmodule

[sv/psgfs_core.sv]
// ----------------------------------------------------------------------------
// psgfs_core
// Update datapath: size register, fill state, sequence stamp and running
// sum; forms the table write for a load or point set.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psgfs_core
    import psgfs_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int STAMP_WIDTH = STAMP_W_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [SIZE_W-1:0]      cfg_data,
    input  pfs_cmd_t               cmd,
    input  logic [INDEX_W-1:0]     req_index,
    input  logic [VALUE_W-1:0]     req_value,
    input  logic [VALUE_W-1:0]     rd_value,
    input  logic [STAMP_WIDTH-1:0] rd_stamp,
    output logic                   wr_en,
    output logic [STAMP_WIDTH-1:0] wr_stamp,
    output logic [SUM_W-1:0]       sum,
    output logic                   err
);

    localparam int CMP_W  = SIZE_W + 2;
    localparam int PROD_W = SIZE_W + VALUE_W;
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);

    logic [SIZE_W-1:0]      table_size_reg;
    logic [STAMP_WIDTH-1:0] seq_reg;
    logic [VALUE_W-1:0]     fill_value_reg;
    logic [STAMP_WIDTH-1:0] fill_stamp_reg;
    logic                   fill_active_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic                   err_reg;

    logic [SIZE_W-1:0]      eff_size;
    logic                   in_range;
    logic                   live;
    logic [VALUE_W-1:0]     old_value;
    logic [PROD_W-1:0]      product;
    logic [SUM_W-1:0]       sum_next;
    logic                   err_next;
    logic                   advance;
    logic                   fill_take;

    // Saturate the size to the table depth.
    assign eff_size = ({2'b00, table_size_reg} > DEPTH_CMP) ? DEPTH_CMP[SIZE_W-1:0]
                                                           : table_size_reg;
    assign in_range = {1'b0, req_index} < eff_size;

    // Entry holds its own value unless a fill came after its last write.
    assign live      = !fill_active_reg || (rd_stamp > fill_stamp_reg);
    assign old_value = live ? rd_value : fill_value_reg;
    assign product   = PROD_W'(eff_size) * PROD_W'(req_value);

    always_comb
    begin
        sum_next  = sum_reg;
        err_next  = 1'b0;
        wr_en     = 1'b0;
        advance   = 1'b0;
        fill_take = 1'b0;
        case (cmd.action)
            ACT_LOAD:
            begin
                if (in_range)
                begin
                    sum_next = sum_reg + SUM_W'(req_value);
                    wr_en    = cmd.commit;
                    advance  = 1'b1;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
            ACT_SET:
            begin
                if (in_range)
                begin
                    sum_next = sum_reg + SUM_W'(req_value) - SUM_W'(old_value);
                    wr_en    = cmd.commit;
                    advance  = 1'b1;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
            ACT_FILL:
            begin
                sum_next  = product[SUM_W-1:0];
                advance   = 1'b1;
                fill_take = 1'b1;
            end
            default:
            begin
                sum_next = sum_reg;
            end
        endcase
    end

    assign wr_stamp = seq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg  <= SIZE_RESET;
            seq_reg         <= STAMP_WIDTH'(1);
            fill_value_reg  <= '0;
            fill_stamp_reg  <= '0;
            fill_active_reg <= 1'b0;
            sum_reg         <= '0;
            err_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                table_size_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                sum_reg <= sum_next;
                err_reg <= err_next;
                if (advance)
                begin
                    seq_reg <= seq_reg + 1'b1;
                end
                if (fill_take)
                begin
                    fill_value_reg  <= req_value;
                    fill_stamp_reg  <= seq_reg;
                    fill_active_reg <= 1'b1;
                end
            end
        end
    end

    assign sum = sum_reg;
    assign err = err_reg;

    `ASSERT_IMPLY(a_write_in_range, wr_en, cmd.commit && in_range && !err_next, "table write outside a valid request")
    `ASSERT_NEXT(a_seq_step, cmd.commit && (wr_en || fill_take), seq_reg == STAMP_WIDTH'($past(seq_reg) + 1'b1), "sequence did not advance")

endmodule

[sv/point_set_global_fill_sum.sv]
// ----------------------------------------------------------------------------
// point_set_global_fill_sum
// Running sum over an entry table with load, point set and lazy global fill.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  --------  -------------------  ---------------------------------------
//  in        in_valid / in_ready  action, entry_index, new_value
//  out       out_valid/ out_ready table_sum, index_error
//  cfg       cfg_we               cfg_data (table_size)
//
//  Steps: a request first reads its entry from the table memory, then
//  updates the sum and writes the entry back.
//  Stalls: the next request is taken while the previous result waits; the
//  update then holds until out_ready frees the result register.
//  Reset: size 1024, sum zero, no fill; the table is never cleared, an entry
//  reads only after it has been written or overridden by a fill.
//
`include "assert_macros.svh"

module point_set_global_fill_sum
    import psgfs_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int STAMP_WIDTH = STAMP_W_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic [INDEX_W-1:0] entry_index,
    input  logic [VALUE_W-1:0] new_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [SUM_W-1:0]   table_sum,
    output logic               index_error,
    input  logic               cfg_we,
    input  logic [SIZE_W-1:0]  cfg_data
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Held request while its entry is read and updated.
    logic [1:0]         req_action_reg;
    logic [INDEX_W-1:0] req_index_reg;
    logic [VALUE_W-1:0] req_value_reg;

    logic                   accept;
    logic                   commit;
    pfs_cmd_t               cmd;
    logic [VALUE_W-1:0]     rd_value;
    logic [STAMP_WIDTH-1:0] rd_stamp;
    logic                   wr_en;
    logic [STAMP_WIDTH-1:0] wr_stamp;

    assign accept = in_valid && in_ready;

    // Sequencer: read on accept, commit once the result register is free.
    // A write lands before the next read is issued, so no forwarding is needed.
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = commit || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the request payload; no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_action_reg <= action;
            req_index_reg  <= entry_index;
            req_value_reg  <= new_value;
        end
    end

    assign cmd.commit = commit;
    assign cmd.action = req_action_reg;

    psgfs_table #(
        .DEPTH       (DEPTH),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_table (
        .clk      (clk),
        .rd_en    (accept),
        .rd_index (entry_index),
        .rd_value (rd_value),
        .rd_stamp (rd_stamp),
        .wr_en    (wr_en),
        .wr_index (req_index_reg),
        .wr_value (req_value_reg),
        .wr_stamp (wr_stamp)
    );

    psgfs_core #(
        .DEPTH       (DEPTH),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .req_index (req_index_reg),
        .req_value (req_value_reg),
        .rd_value  (rd_value),
        .rd_stamp  (rd_stamp),
        .wr_en     (wr_en),
        .wr_stamp  (wr_stamp),
        .sum       (table_sum),
        .err       (index_error)
    );

    assign out_valid = out_valid_reg;

    `ASSERT_IMPLY(a_commit_slot_free, commit, !out_valid_reg || out_ready, "commit over a pending result")
    `ASSERT_NEXT(a_one_in_flight, accept, !in_ready && state_reg == ST_EXEC, "second request taken in flight")

endmodule

[tb/point_set_global_fill_sum_checker.sv]
// ----------------------------------------------------------------------------
// point_set_global_fill_sum_checker
// Watches the request, result and size-write ports of the table sum block,
// keeps its own copy of the table, fill record and running sum, and compares
// every result's sum and error flag with its matching request's prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_set_global_fill_sum_checker
    import psgfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         action,
    input  logic [INDEX_W-1:0] entry_index,
    input  logic [VALUE_W-1:0] new_value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [SUM_W-1:0]   table_sum,
    input  logic               index_error,
    input  logic               cfg_we,
    input  logic [SIZE_W-1:0]  cfg_data,
    output int                 fail_count,
    output int                 pending_count,
    output int                 result_count,
    output int                 flagged_count
);

    localparam int REPORT_LIMIT = 40;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             err;
    } sum_result_t;

    sum_result_t expected_sums[$];
    sum_result_t oldest;
    sum_result_t predicted;

    logic [VALUE_W-1:0]     entry_val   [DEPTH_DEF];
    logic [STAMP_W_DEF-1:0] entry_stamp [DEPTH_DEF];
    logic [STAMP_W_DEF-1:0] seq_count;
    logic [STAMP_W_DEF-1:0] fill_stamp;
    logic [VALUE_W-1:0]     fill_val;
    logic [VALUE_W-1:0]     prior_val;
    logic                   fill_on;
    logic                   entry_live;
    logic                   req_err;
    logic [SUM_W-1:0]       model_sum;
    logic [SIZE_W-1:0]      size_reg;
    int                     eff_size;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH_DEF; i++)
            begin
                entry_val[i]   = '0;
                entry_stamp[i] = '0;
            end
            seq_count     = 1;
            fill_stamp    = '0;
            fill_val      = '0;
            fill_on       = 1'b0;
            model_sum     = '0;
            size_reg      = SIZE_RESET;
            expected_sums.delete();
            fail_count    = 0;
            pending_count = 0;
            result_count  = 0;
            flagged_count = 0;
        end
        else
        begin
            // Retire the oldest prediction first; the block never answers
            // a request in the cycle it takes it.
            if (out_valid && out_ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: result with no request pending, table_sum %h index_error %b",
                                 $time, table_sum, index_error);
                end
                else
                begin
                    oldest = expected_sums.pop_front();
                    result_count++;
                    if (index_error)
                        flagged_count++;
                    if (table_sum !== oldest.sum)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("%0t: table_sum mismatch, expected %h, actual %h",
                                     $time, oldest.sum, table_sum);
                    end
                    if (index_error !== oldest.err)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("%0t: index_error mismatch, expected %b, actual %b",
                                     $time, oldest.err, index_error);
                    end
                end
            end

            if (in_valid && in_ready)
            begin : sum_model
                eff_size = (size_reg > DEPTH_DEF) ? DEPTH_DEF : int'(size_reg);
                req_err  = 1'b0;
                case (action) inside
                    ACT_LOAD, ACT_SET:
                    begin
                        if (int'(entry_index) >= eff_size)
                            req_err = 1'b1;
                        else
                        begin
                            if (action == ACT_LOAD)
                                model_sum = model_sum + SUM_W'(new_value);
                            else
                            begin
                                // Stale entries read as the last fill value.
                                entry_live = !fill_on
                                             || (entry_stamp[entry_index] > fill_stamp);
                                prior_val  = entry_live ? entry_val[entry_index] : fill_val;
                                model_sum  = model_sum + SUM_W'(new_value) - SUM_W'(prior_val);
                            end
                            entry_val[entry_index]   = new_value;
                            entry_stamp[entry_index] = seq_count;
                            seq_count++;
                        end
                    end
                    ACT_FILL:
                    begin
                        model_sum  = SUM_W'(eff_size) * SUM_W'(new_value);
                        fill_val   = new_value;
                        fill_stamp = seq_count;
                        fill_on    = 1'b1;
                        seq_count++;
                    end
                    default:
                    begin
                        // Undefined code: sum held, sequence not advanced.
                    end
                endcase
                predicted.sum = model_sum;
                predicted.err = req_err;
                expected_sums = {expected_sums, predicted};
            end

            if (cfg_we)
                size_reg = cfg_data;

            pending_count = expected_sums.size();
        end
    end

endmodule

[tb/point_set_global_fill_sum_test.sv]
// ----------------------------------------------------------------------------
// point_set_global_fill_sum_test
// Drives loads, point sets, global fills and undefined codes into the table
// sum block under several table sizes, with random gaps on both channels,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_set_global_fill_sum_test
    import psgfs_pkg::*;
();

    // Code 3 has no member in the package; keep a name for it here.
    localparam logic [1:0] ACT_UNDEFINED = 2'd3;
    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

    logic               clk         = 1'b0;
    logic               rst_n;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [1:0]         action      = '0;
    logic [INDEX_W-1:0] entry_index = '0;
    logic [VALUE_W-1:0] new_value   = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic [SUM_W-1:0]   table_sum;
    logic               index_error;
    logic               cfg_we      = 1'b0;
    logic [SIZE_W-1:0]  cfg_data    = '0;

    int fail_count;
    int pending_count;
    int result_count;
    int flagged_count;

    // Stimulus bookkeeping: which entries hold a written value, so that a
    // point set never lands on a live entry that was never written.
    bit entry_written [DEPTH_DEF];
    int written_list[$];
    int cur_eff     = DEPTH_DEF;
    int size_count  = 1;
    int request_count [4];
    bit steady      = 1'b0;

    always #2 clk = ~clk;

    point_set_global_fill_sum i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .entry_index (entry_index),
        .new_value   (new_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .table_sum   (table_sum),
        .index_error (index_error),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data)
    );

    point_set_global_fill_sum_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .entry_index   (entry_index),
        .new_value     (new_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .table_sum     (table_sum),
        .index_error   (index_error),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count),
        .flagged_count (flagged_count)
    );

    // Idle length: mostly none or short, now and then long; none at all
    // while a steady stretch runs.
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (steady)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 80);
    endfunction

    // Bias values toward the edges so the 42-bit sum wraps often.
    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r) inside
            0:       return '0;
            1:       return VALUE_MAX;
            2, 3:    return VALUE_W'($urandom_range(0, 255));
            4:       return VALUE_MAX - VALUE_W'($urandom_range(0, 255));
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // Offer one request. Called at a falling edge; returns at the falling
    // edge after acceptance with valid still high, so the next call can
    // either keep it high with a new payload or drop it for a gap.
    task automatic send_request(input logic [1:0] act, input logic [INDEX_W-1:0] idx,
                                input logic [VALUE_W-1:0] val);
        int n;
        n = gap_cycles();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        entry_index <= idx;
        new_value   <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if ((act == ACT_LOAD || act == ACT_SET) && int'(idx) < cur_eff && !entry_written[idx])
        begin
            entry_written[idx] = 1'b1;
            written_list = {written_list, int'(idx)};
        end
        request_count[act]++;
        @(negedge clk);
    endtask

    // Hold the sender until every outstanding result has been taken, then
    // let the pipeline settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Write table_size only with the block idle.
    task automatic write_table_size(input logic [SIZE_W-1:0] size);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= size;
        @(negedge clk);
        cfg_we   <= 1'b0;
        cur_eff = (size > DEPTH_DEF) ? DEPTH_DEF : int'(size);
        size_count++;
    endtask

    // Random requests: mostly in-range loads and point sets on written
    // entries, with fills interleaved so both live and stale entries get
    // overwritten; the rest are out-of-range requests and undefined codes.
    task automatic run_random(input int count);
        int                 r;
        logic [1:0]         act;
        logic [INDEX_W-1:0] idx;
        logic [VALUE_W-1:0] val;
        for (int i = 0; i < count; i++)
        begin
            // Now and then hold off until the result side is empty.
            if ($urandom_range(0, 249) == 0)
                drain_results();
            r   = $urandom_range(0, 99);
            idx = INDEX_W'($urandom);
            val = pick_value();
            if (r < 38)
            begin
                act = ACT_LOAD;
                if (cur_eff > 0 && $urandom_range(0, 9) != 0)
                    idx = INDEX_W'($urandom_range(0, cur_eff - 1));
            end
            else if (r < 73)
            begin
                act = ACT_SET;
                if (cur_eff < DEPTH_DEF && $urandom_range(0, 9) == 0)
                    idx = INDEX_W'($urandom_range(cur_eff, DEPTH_DEF - 1));
                else if (written_list.size() > 0)
                    idx = INDEX_W'(written_list[$urandom_range(0, written_list.size() - 1)]);
                else if (cur_eff < DEPTH_DEF)
                    idx = INDEX_W'($urandom_range(cur_eff, DEPTH_DEF - 1));
                else
                    act = ACT_LOAD;
            end
            else if (r < 88)
                act = ACT_FILL;
            else if (r < 94)
            begin
                act = ACT_LOAD;
                if (cur_eff < DEPTH_DEF)
                    idx = INDEX_W'($urandom_range(cur_eff, DEPTH_DEF - 1));
            end
            else
                act = ACT_UNDEFINED;
            send_request(act, idx, val);
        end
    endtask

    // Result side: random stalls, long ready stretches in between.
    initial
    begin : ready_driver
        int hold;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (steady)
                out_ready <= 1'b1;
            else if (hold > 0)
                hold--;
            else if ($urandom_range(0, 99) < 65)
            begin
                out_ready <= 1'b1;
                hold = $urandom_range(0, 15);
            end
            else
            begin
                out_ready <= 1'b0;
                hold = gap_cycles();
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset size: extremes of index and value, live point sets, an
        // undefined code, a fill near the top of the sum, stale point sets,
        // a load over a written entry and a wrapping sum.
        send_request(ACT_LOAD, 10'd0, VALUE_MAX);
        send_request(ACT_LOAD, 10'd1023, 32'd5);
        send_request(ACT_SET, 10'd0, 32'd0);
        send_request(ACT_SET, 10'd1023, VALUE_MAX);
        send_request(ACT_UNDEFINED, 10'd1023, 32'd0);
        send_request(ACT_FILL, 10'd1023, VALUE_MAX);
        send_request(ACT_SET, 10'd0, 32'd7);
        send_request(ACT_LOAD, 10'd0, VALUE_MAX);
        send_request(ACT_LOAD, 10'd5, VALUE_MAX);
        send_request(ACT_SET, 10'd5, 32'd1);
        send_request(ACT_FILL, 10'd0, 32'd0);
        send_request(ACT_SET, 10'd1023, 32'd3);
        send_request(ACT_UNDEFINED, 10'd0, VALUE_MAX);

        // Size zero: every load and point set flagged, a fill sums to zero.
        write_table_size(11'd0);
        send_request(ACT_LOAD, 10'd0, 32'd1);
        send_request(ACT_SET, 10'd0, 32'd2);
        send_request(ACT_FILL, 10'd0, 32'd9);
        run_random(60);

        // One entry in use.
        write_table_size(11'd1);
        send_request(ACT_LOAD, 10'd1, 32'd4);
        send_request(ACT_LOAD, 10'd0, 32'd8);
        send_request(ACT_SET, 10'd0, VALUE_MAX);
        send_request(ACT_FILL, 10'd0, 32'd6);
        send_request(ACT_SET, 10'd0, 32'd2);
        run_random(100);

        // Oversized register saturates to the full table.
        write_table_size(11'd2047);
        send_request(ACT_LOAD, 10'd1023, VALUE_MAX);
        send_request(ACT_FILL, 10'd0, 32'd2);
        send_request(ACT_SET, 10'd1023, 32'd1);
        run_random(350);

        write_table_size(11'd1025);
        run_random(150);

        write_table_size(SIZE_W'($urandom_range(2, 1023)));
        run_random(300);

        // Back to the full table: a stretch with no idling, then gaps again.
        write_table_size(11'd1024);
        steady = 1'b1;
        run_random(200);
        steady = 1'b0;
        run_random(240);

        // Drop valid and let every outstanding result come back.
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Covered %0d requests (%0d loads, %0d point sets, %0d fills, %0d undefined)",
                 request_count[0] + request_count[1] + request_count[2] + request_count[3],
                 request_count[0], request_count[1], request_count[2], request_count[3]);
        $display("over %0d table sizes; checked %0d results, %0d of them flagged out of range.",
                 size_count, result_count, flagged_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/psgfs_pkg.sv
sv/psgfs_table.sv
sv/psgfs_core.sv
sv/point_set_global_fill_sum.sv
tb/point_set_global_fill_sum_checker.sv
tb/point_set_global_fill_sum_test.sv
